>>> rtl/core/mts_pkg.sv
// Shared types and constants for the mip texture sampler.
// No dependencies; mts_front, mts_back, the top level and the testbench import it.
`default_nettype none
package mts_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WGT,
    ST_ACC,
    ST_DONE
  } back_state_t;

  localparam logic ACT_WRITE      = 1'b0;
  localparam logic ACT_SAMPLE     = 1'b1;
  localparam logic FILTER_NEAREST = 1'b0;
  localparam logic FILTER_BILIN   = 1'b1;

  localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [1:0] CFG_BASE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_BASE_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_LEVEL_COUNT = 2'd3;

  localparam int CH_W    = 8;
  localparam int WGT_W   = 8;
  localparam int BWT_W   = 17;
  localparam int ACC_W   = 25;
  localparam int TEXEL_W = 32;

  // Field offsets inside a queue entry; the texel addresses follow ADDR_LSB.
  localparam int DATA_LSB = 0;
  localparam int WX_LSB   = 32;
  localparam int WY_LSB   = 40;
  localparam int ADDR_LSB = 48;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
  localparam logic [TEXEL_W-1:0] MAGENTA  = 32'hFFFF00FF;

endpackage
`default_nettype wire

>>> rtl/core/mts_if.sv
// Channel interfaces of the mip texture sampler: input, result, config write.
// Depends on nothing; widths follow the fixed field widths.
`default_nettype none
interface mts_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         level;
  logic [5:0]         texel_x;
  logic [5:0]         texel_y;
  logic [31:0]        texel_rgba;
  logic signed [19:0] u_coord;
  logic signed [19:0] v_coord;
  modport source(output valid, action, level, texel_x, texel_y, texel_rgba, u_coord,
                 v_coord, input ready);
  modport sink(input valid, action, level, texel_x, texel_y, texel_rgba, u_coord,
               v_coord, output ready);
endinterface

interface mts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       bad_level;
  modport source(output valid, red, green, blue, alpha, bad_level, input ready);
  modport sink(input valid, red, green, blue, alpha, bad_level, output ready);
endinterface

interface mts_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [6:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mts_front.sv
// Front end: configuration registers, item classification, texel address and
// weight computation. Depends on mts_pkg and mts_if.
`default_nettype none
module mts_front #(
  parameter int MAX_SIZE   = 64,
  parameter int LEVELS     = 7,
  parameter int COORD_FRAC = 16,
  parameter int AW         = 15,
  parameter int EW         = 48 + 4 * 15 + 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mts_in_if.sink             in_ch,
  mts_cfg_if.sink            cfg_ch,
  output logic               q_valid,
  input  wire logic          q_ready,
  output logic [EW-1:0]      q_data
);
  import mts_pkg::*;

  localparam int DW  = $clog2(MAX_SIZE + 1);
  localparam int SZW = $clog2(MAX_SIZE);
  localparam int CF  = COORD_FRAC;
  localparam int PW  = CF + DW + 22;
  localparam int MW  = 20 + DW + 1;
  localparam logic signed [PW-1:0] HALF   = PW'(1) <<< (CF - 1);
  localparam logic signed [PW-1:0] ONE_M1 = (PW'(1) <<< CF) - PW'(1);

  logic       filter_mode_r;
  logic [6:0] base_width_r;
  logic [6:0] base_height_r;
  logic [2:0] level_count_r;

  logic            is_wr, wr_ok, bad, bil;
  logic [DW-1:0]   dim_w, dim_h;
  logic [SZW-1:0]  x0, x1, y0, y1;
  logic [7:0]      wx, wy;
  logic [AW-1:0]   a0, a1, a2, a3;

  function automatic logic [DW-1:0] level_dim(input logic [6:0] base, input logic [3:0] lvl);
    logic [DW-1:0] b;
    if (base == 7'd0) b = DW'(1);
    else if (32'(base) > MAX_SIZE) b = DW'(MAX_SIZE);
    else b = DW'(base);
    b = b >> lvl;
    if (b == '0) b = DW'(1);
    return b;
  endfunction

  function automatic logic [SZW-1:0] clampi(input logic signed [PW-1:0] v,
                                            input logic [DW-1:0] d);
    logic signed [PW-1:0] ds;
    logic [DW-1:0] dm1;
    ds  = PW'(d);
    dm1 = d - DW'(1);
    if (v < 0) return '0;
    else if (v >= ds) return SZW'(dm1);
    else return SZW'(v);
  endfunction

  function automatic logic [AW-1:0] texel_addr(input logic [3:0] lvl,
                                               input logic [SZW-1:0] y,
                                               input logic [SZW-1:0] x);
    return AW'((AW'(lvl) * AW'(MAX_SIZE) + AW'(y)) * AW'(MAX_SIZE) + AW'(x));
  endfunction

  // Nearest mode reuses the bilinear path with zero weights and one texel.
  function automatic void axis(input logic signed [19:0] c, input logic [DW-1:0] d,
                               input logic b, output logic [SZW-1:0] i0,
                               output logic [SZW-1:0] i1, output logic [7:0] w);
    logic signed [PW-1:0] cs, m, p, fl;
    logic signed [MW-1:0] cm, dm;
    cs = PW'(c);
    if (!b) begin
      if (cs < 0) cs = '0;
      else if (cs > ONE_M1) cs = ONE_M1;
    end
    cm = MW'(cs);
    dm = MW'(d);
    m  = PW'(cm * dm);
    p  = b ? m - HALF : m;
    fl = p >>> CF;
    i0 = clampi(fl, d);
    i1 = b ? clampi(fl + PW'(1), d) : i0;
    w  = b ? p[CF-1 -: 8] : 8'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= FILTER_BILIN;
      base_width_r  <= 7'd64;
      base_height_r <= 7'd64;
      level_count_r <= 3'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_FILTER_MODE: filter_mode_r <= cfg_ch.data[0];
        CFG_BASE_WIDTH:  base_width_r  <= cfg_ch.data;
        CFG_BASE_HEIGHT: base_height_r <= cfg_ch.data;
        CFG_LEVEL_COUNT: level_count_r <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    is_wr = (in_ch.action == ACT_WRITE);
    wr_ok = (32'(in_ch.level) < LEVELS) && (32'(in_ch.texel_x) < MAX_SIZE)
            && (32'(in_ch.texel_y) < MAX_SIZE);
    bad   = (in_ch.level >= {1'b0, level_count_r}) || (32'(in_ch.level) >= LEVELS);
    bil   = (filter_mode_r == FILTER_BILIN);
    dim_w = level_dim(base_width_r, in_ch.level);
    dim_h = level_dim(base_height_r, in_ch.level);
    axis(in_ch.u_coord, dim_w, bil, x0, x1, wx);
    axis(in_ch.v_coord, dim_h, bil, y0, y1, wy);
    if (is_wr) begin
      a0 = texel_addr(in_ch.level, SZW'(in_ch.texel_y), SZW'(in_ch.texel_x));
      a1 = a0;
      a2 = a0;
      a3 = a0;
    end else begin
      a0 = texel_addr(in_ch.level, y0, x0);
      a1 = texel_addr(in_ch.level, y0, x1);
      a2 = texel_addr(in_ch.level, y1, x0);
      a3 = texel_addr(in_ch.level, y1, x1);
    end
  end

  // An out-of-range write is accepted and dropped here.
  assign in_ch.ready = q_ready;
  assign q_valid     = in_ch.valid && !(is_wr && !wr_ok);
  assign q_data      = {is_wr, bad && !is_wr, a3, a2, a1, a0, wy, wx, in_ch.texel_rgba};

endmodule
`default_nettype wire

>>> rtl/core/mts_queue.sv
// Two-entry queue between the sampler's front and back ends.
// Depends on nothing but the payload width parameter.
`default_nettype none
module mts_queue #(
  parameter int EW = 110
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [EW-1:0] push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output logic [EW-1:0]      pop_data
);
  logic [EW-1:0] slot_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mts_back.sv
// Back end: texel memory, four-read bilinear blend and result register.
// Depends on mts_pkg and mts_if.
`default_nettype none
module mts_back #(
  parameter int AW    = 15,
  parameter int DEPTH = 28672,
  parameter int EW    = 48 + 4 * 15 + 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire logic [EW-1:0] q_data,
  mts_out_if.source          out_ch
);
  import mts_pkg::*;

  back_state_t st_r, st_nxt;
  logic [EW-1:0]        e_r;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [BWT_W-1:0]     wt_r [4];
  logic [ACC_W-1:0]     acc_r [4];
  logic [TEXEL_W-1:0]   mem [DEPTH];
  logic [TEXEL_W-1:0]   rd_r;
  logic [AW-1:0]        rd_addr;
  logic                 pop, wr_en, load_out;
  logic                 out_valid_r, out_bad_r;
  logic [TEXEL_W-1:0]   out_rgba_r, blend;
  logic [8:0]           wx9, wy9, iwx9, iwy9;
  logic [ACC_W-1:0]     rsum [4];

  assign pop   = (st_r == ST_IDLE) && q_valid;
  assign wr_en = pop && q_data[EW-1];
  assign wx9   = {1'b0, e_r[WX_LSB +: WGT_W]};
  assign wy9   = {1'b0, e_r[WY_LSB +: WGT_W]};
  assign iwx9  = 9'd256 - wx9;
  assign iwy9  = 9'd256 - wy9;
  assign rd_addr = (st_r == ST_WGT) ? e_r[ADDR_LSB +: AW]
                                    : e_r[ADDR_LSB + 32'(cnt_r + 2'd1) * AW +: AW];
  assign load_out = (st_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rsum[k] = acc_r[k] + ROUND_HALF;
      blend[CH_W*k +: CH_W] = rsum[k][16 +: CH_W];
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    q_ready = (st_r == ST_IDLE);
    case (st_r)
      ST_IDLE: begin
        if (q_valid && !q_data[EW-1]) st_nxt = q_data[EW-2] ? ST_DONE : ST_WGT;
      end
      ST_WGT: begin
        cnt_nxt = 2'd0;
        st_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[q_data[ADDR_LSB +: AW]] <= q_data[DATA_LSB +: TEXEL_W];
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop) e_r <= q_data;
    if (st_r == ST_WGT) begin
      wt_r[0] <= BWT_W'(iwx9) * BWT_W'(iwy9);
      wt_r[1] <= BWT_W'(wx9) * BWT_W'(iwy9);
      wt_r[2] <= BWT_W'(iwx9) * BWT_W'(wy9);
      wt_r[3] <= BWT_W'(wx9) * BWT_W'(wy9);
      for (int k = 0; k < 4; k++) acc_r[k] <= '0;
    end else if (st_r == ST_ACC) begin
      for (int k = 0; k < 4; k++) begin
        acc_r[k] <= acc_r[k] + ACC_W'(wt_r[cnt_r]) * ACC_W'(rd_r[CH_W*k +: CH_W]);
      end
    end
    if (load_out) begin
      out_bad_r  <= e_r[EW-2];
      out_rgba_r <= e_r[EW-2] ? MAGENTA : blend;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red       = out_rgba_r[0 +: CH_W];
  assign out_ch.green     = out_rgba_r[CH_W +: CH_W];
  assign out_ch.blue      = out_rgba_r[2*CH_W +: CH_W];
  assign out_ch.alpha     = out_rgba_r[3*CH_W +: CH_W];
  assign out_ch.bad_level = out_bad_r;

`ifndef SYNTHESIS
  a_wgt_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_WGT |=> st_r == ST_ACC && cnt_r == 2'd0)
    else $error("weight setup not followed by first accumulate");
  a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ACC && cnt_r == 2'd3 |=> st_r == ST_DONE)
    else $error("blend did not finish after four texels");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> st_r == ST_IDLE)
    else $error("queue popped while busy");
  a_bad_magenta: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && e_r[EW-2] |=> out_ch.red == 8'hFF && out_ch.green == 8'h00)
    else $error("bad level result not magenta");
`endif

endmodule
`default_nettype wire

>>> rtl/core/mip_texture_sampler.sv
// Channel    Dir  Handshake          Payload
// in_ch      in   valid/ready        action, level, texel_x/y, texel_rgba, u/v_coord
// out_ch     out  valid/ready        red, green, blue, alpha, bad_level
// cfg_ch     in   valid/ready (=1)   addr (register index), data
// A write is done at the pop; a sample goes through the pop, weight setup,
// four reads through the single texel memory port, then the result register.
// A sample at a bad level goes from the pop straight to the result register.
// Reset (synchronous, rst_n low) clears control and config; texels stay unset.
// A two-entry queue lets the front accept while the back end or output stalls.
// Top level; depends on mts_pkg, mts_if, mts_front, mts_queue and mts_back.
`default_nettype none
module mip_texture_sampler #(
  parameter int MAX_SIZE   = 64,
  parameter int LEVELS     = 7,
  parameter int COORD_FRAC = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch,
  mts_cfg_if.sink   cfg_ch
);
  import mts_pkg::*;

  localparam int DEPTH = LEVELS * MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = ADDR_LSB + 4 * AW + 2;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [EW-1:0] f_data, b_data;

  mts_front #(.MAX_SIZE(MAX_SIZE), .LEVELS(LEVELS), .COORD_FRAC(COORD_FRAC), .AW(AW),
              .EW(EW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  mts_queue #(.EW(EW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
  );

  mts_back #(.AW(AW), .DEPTH(DEPTH), .EW(EW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

>>> test/mts_scoreboard.sv
// Scoreboard and texel predictor for the mip texture sampler testbench.
// Depends on mts_pkg; holds its own copy of the texel store and the registers.
package mts_tb_pkg;
  import mts_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       bad_level;
  } sample_t;

  class sample_board;
    logic [31:0] texels [int];
    logic        filter_mode;
    logic [6:0]  base_width;
    logic [6:0]  base_height;
    logic [2:0]  level_count;
    sample_t     pending [$];
    int          errors;

    function new();
      filter_mode = FILTER_BILIN;
      base_width  = 7'd64;
      base_height = 7'd64;
      level_count = 3'd1;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        CFG_FILTER_MODE: filter_mode = val[0];
        CFG_BASE_WIDTH:  base_width  = val;
        CFG_BASE_HEIGHT: base_height = val;
        CFG_LEVEL_COUNT: level_count = val[2:0];
        default: ;
      endcase
    endfunction

    function int dim_of(logic [6:0] base, int lvl);
      int b;
      b = base;
      if (b < 1) b = 1;
      if (b > 64) b = 64;
      b = b >> lvl;
      return (b < 1) ? 1 : b;
    endfunction

    function logic [31:0] texel_at(int lvl, int x, int y);
      int a;
      a = (lvl * 64 + y) * 64 + x;
      return texels.exists(a) ? texels[a] : 32'h0;
    endfunction

    function int clampi(int x, int lo, int hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function int near_idx(int c, int d);
      int cc;
      cc = clampi(c, 0, 65535);
      return clampi((cc * d) >>> 16, 0, d - 1);
    endfunction

    // Floor split of c*d - 1/2 into index and 8-bit weight.
    function void split(int c, int d, output int idx, output int wt);
      longint p;
      p = longint'(c) * d - 32768;
      idx = int'(p >>> 16);
      wt = int'((p - longint'(idx) * 65536) >> 8) & 255;
    endfunction

    function void note_item(logic act, logic [3:0] lvl, logic [5:0] tx, logic [5:0] ty,
                            logic [31:0] rgba, logic signed [19:0] u,
                            logic signed [19:0] v);
      sample_t r;
      int w, h, i, j, wx, wy, x0, x1, y0, y1;
      logic [31:0] t00, t10, t01, t11, t;
      int acc;
      if (act == ACT_WRITE) begin
        if (lvl < 7) texels[(int'(lvl) * 64 + ty) * 64 + tx] = rgba;
        return;
      end
      if (lvl >= level_count || lvl >= 7) begin
        r = '{8'd255, 8'd0, 8'd255, 8'd255, 1'b1};
        pending.push_back(r);
        return;
      end
      w = dim_of(base_width, lvl);
      h = dim_of(base_height, lvl);
      if (filter_mode == FILTER_NEAREST) begin
        t = texel_at(lvl, near_idx(u, w), near_idx(v, h));
      end else begin
        split(u, w, i, wx);
        split(v, h, j, wy);
        x0 = clampi(i, 0, w - 1); x1 = clampi(i + 1, 0, w - 1);
        y0 = clampi(j, 0, h - 1); y1 = clampi(j + 1, 0, h - 1);
        t00 = texel_at(lvl, x0, y0); t10 = texel_at(lvl, x1, y0);
        t01 = texel_at(lvl, x0, y1); t11 = texel_at(lvl, x1, y1);
        for (int k = 0; k < 4; k++) begin
          acc = (256 - wx) * (256 - wy) * t00[8*k +: 8] + wx * (256 - wy) * t10[8*k +: 8]
              + (256 - wx) * wy * t01[8*k +: 8] + wx * wy * t11[8*k +: 8];
          t[8*k +: 8] = 8'((acc + 32768) >> 16);
        end
      end
      r = '{t[7:0], t[15:8], t[23:16], t[31:24], 1'b0};
      pending.push_back(r);
    endfunction

    function void check_result(sample_t got);
      sample_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.red !== e.red) begin
        $error("red expected %0d actual %0d", e.red, got.red); errors++;
      end
      if (got.green !== e.green) begin
        $error("green expected %0d actual %0d", e.green, got.green); errors++;
      end
      if (got.blue !== e.blue) begin
        $error("blue expected %0d actual %0d", e.blue, got.blue); errors++;
      end
      if (got.alpha !== e.alpha) begin
        $error("alpha expected %0d actual %0d", e.alpha, got.alpha); errors++;
      end
      if (got.bad_level !== e.bad_level) begin
        $error("bad_level expected %0d actual %0d", e.bad_level, got.bad_level); errors++;
      end
    endfunction
  endclass
endpackage

>>> test/tb_top.sv
// Top of the mip texture sampler testbench: clock, reset, drivers and checks.
// Depends on mts_pkg, mts_if, mts_tb_pkg and the sampler RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mts_pkg::*;
  import mts_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  mts_in_if  in_ch();
  mts_out_if out_ch();
  mts_cfg_if cfg_ch();

  mip_texture_sampler dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                           .cfg_ch(cfg_ch));

  sample_board board = new();
  bit hold_long = 0;

  initial begin
    in_ch.valid = 0; in_ch.action = 0; in_ch.level = 0; in_ch.texel_x = 0;
    in_ch.texel_y = 0; in_ch.texel_rgba = 0; in_ch.u_coord = 0; in_ch.v_coord = 0;
    cfg_ch.valid = 0; cfg_ch.addr = CFG_FILTER_MODE; cfg_ch.data = 0;
    out_ch.ready = 0;
  end

  function int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Side of the stored square at each level: an 8x8 corner, or the whole level.
  function int fill_side(int l);
    return ((64 >> l) < 8) ? (64 >> l) : 8;
  endfunction

  // The receiver stalls at random, and once for a long stretch.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        for (int k = 0; k < 300; k++) @(posedge clk);
        hold_long = 0;
      end
      n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      out_ch.ready <= (n == 0);
      @(posedge clk);
      for (int k = 1; k < n; k++) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                           out_ch.bad_level});
  end

  task automatic send_item(logic act, logic [3:0] lvl, logic [5:0] tx, logic [5:0] ty,
                           logic [31:0] rgba, logic signed [19:0] u, logic signed [19:0] v,
                           bit quick);
    int g;
    g = quick ? 0 : gap_len();
    if ($urandom_range(0, 3) != 0) g = 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.action <= act; in_ch.level <= lvl;
    in_ch.texel_x <= tx; in_ch.texel_y <= ty; in_ch.texel_rgba <= rgba;
    in_ch.u_coord <= u; in_ch.v_coord <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_item(act, lvl, tx, ty, rgba, u, v);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.addr <= idx; cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_reg(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  // Fill the stored square of levels 0..6 so every read below sees stored data.
  task automatic fill_all();
    for (int l = 0; l < 7; l++)
      for (int y = 0; y < fill_side(l); y++)
        for (int x = 0; x < fill_side(l); x++)
          send_item(ACT_WRITE, l, x, y, $urandom(), 0, 0, 1);
  endtask

  task automatic sample_rand(bit wide);
    logic signed [19:0] u, v;
    logic [3:0] lvl;
    if (wide) begin
      u = $urandom(); v = $urandom();
    end else begin
      u = $urandom_range(0, 81920) - 8192; v = $urandom_range(0, 81920) - 8192;
    end
    lvl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6);
    // A valid level must fit inside the stored square; level 3 and up always do.
    while (lvl < 7 && lvl < board.level_count
           && (board.dim_of(board.base_width, lvl) > fill_side(lvl)
               || board.dim_of(board.base_height, lvl) > fill_side(lvl)))
      lvl++;
    send_item(ACT_SAMPLE, lvl, $urandom(), $urandom(), $urandom(), u, v, 0);
  endtask

  initial begin
    logic [6:0] widths [6];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CFG_LEVEL_COUNT, 7);
    write_reg(CFG_BASE_WIDTH, 8);
    write_reg(CFG_BASE_HEIGHT, 8);
    fill_all();
    // Out-of-range writes are dropped; they must not change stored texels.
    send_item(ACT_WRITE, 4'd7, 6'd63, 6'd63, 32'hFFFFFFFF, 0, 0, 0);
    send_item(ACT_WRITE, 4'd15, 6'd0, 6'd0, 32'h0, 0, 0, 0);
    // Directed samples: extreme coordinates, bad levels, both modes.
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 20'sh80000, 20'sh80000, 0);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 20'sh7FFFF, 20'sh7FFFF, 0);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 20'sh00000, 20'sh10000, 0);
    send_item(ACT_SAMPLE, 6, 0, 0, 0, 20'sh08000, 20'sh08000, 0);
    send_item(ACT_SAMPLE, 7, 0, 0, 0, 0, 0, 0);
    send_item(ACT_SAMPLE, 15, 6'h3F, 6'h3F, 32'hFFFFFFFF, 0, 0, 0);
    drain();
    write_reg(CFG_FILTER_MODE, FILTER_NEAREST);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 20'sh80000, 20'sh7FFFF, 0);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 20'sh0FFFF, 20'sh00000, 0);
    send_item(ACT_SAMPLE, 3, 0, 0, 0, 20'sh04000, 20'sh0C000, 0);
    drain();
    write_reg(CFG_LEVEL_COUNT, 0);
    send_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0);
    drain();
    // Random phases over several register settings.
    widths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd37, 7'd5};
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_FILTER_MODE, ph[0]);
      write_reg(CFG_BASE_WIDTH, (ph < 6) ? widths[ph] : $urandom());
      write_reg(CFG_BASE_HEIGHT, (ph < 6) ? widths[5 - ph] : $urandom());
      write_reg(CFG_LEVEL_COUNT, (ph == 3) ? 1 : ((ph == 4) ? 3 : $urandom_range(1, 7)));
      if (ph == 5) hold_long = 1;
      for (int n = 0; n < 35; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Rewriting a texel inside the stored square keeps every read defined.
          int l;
          l = $urandom_range(0, 6);
          send_item(ACT_WRITE, l, $urandom_range(0, fill_side(l) - 1),
                    $urandom_range(0, fill_side(l) - 1), $urandom(), $urandom(),
                    $urandom(), 0);
        end else begin
          sample_rand($urandom_range(0, 3) == 0);
        end
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
